[sv/ptt_pkg.sv]
// Shared constants, codes and interface types of the periodic task timer bank.
package ptt_pkg;

    localparam int CHANNELS     = 8;
    localparam int PERIOD_BITS  = 16;
    localparam int CH_IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MASK_W       = 8;
    localparam int RESET_PERIOD = 1000;
    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_ALLOC    = 3'd1,
        CMD_SET_PER  = 3'd2,
        CMD_TEST_CLR = 3'd3,
        CMD_RD_TIME  = 3'd4,
        CMD_SW_START = 3'd5,
        CMD_ELAPSED  = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        BOP_NONE  = 3'd0,
        BOP_STEP  = 3'd1,
        BOP_ALLOC = 3'd2,
        BOP_LOAD  = 3'd3,
        BOP_CLEAR = 3'd4
    } t_bank_op;

    typedef struct packed {
        t_bank_op                op;
        logic [CH_IDX_W-1:0]     idx;
        logic [PERIOD_BITS-1:0]  period;
        logic                    in_main;
    } t_bank_req;

    typedef struct packed {
        logic        fire;
        logic [7:0]  pending;
        logic        alloc_ok;
        logic [2:0]  alloc_idx;
    } t_bank_rsp;

endpackage

[sv/ptt_chan_bank.sv]
// Per-channel timer state with one shared countdown/update unit, one channel per cycle.
module ptt_chan_bank (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ptt_pkg::t_bank_req i_req,
    output ptt_pkg::t_bank_rsp o_rsp
);
    import ptt_pkg::*;

    logic [CHANNELS-1:0]    r_used;
    logic [CHANNELS-1:0]    r_main;
    logic [PERIOD_BITS-1:0] r_reload [CHANNELS];
    logic [PERIOD_BITS-1:0] r_cd     [CHANNELS];
    logic [7:0]             r_cnt    [CHANNELS];

    logic                   found_ok;
    logic [CH_IDX_W-1:0]    found_idx;
    logic [CH_IDX_W-1:0]    addr;
    logic [PERIOD_BITS-1:0] cd_rd;
    logic [7:0]             cnt_rd;
    logic                   cd_zero;

    // highest free slot wins
    always_comb begin
        found_ok  = 1'b0;
        found_idx = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (!r_used[i]) begin
                found_ok  = 1'b1;
                found_idx = CH_IDX_W'(i);
            end
        end
    end

    assign addr    = (i_req.op == BOP_ALLOC) ? found_idx : i_req.idx;
    assign cd_rd   = r_cd[addr];
    assign cnt_rd  = r_cnt[addr];
    assign cd_zero = (cd_rd == '0);

    always_comb begin
        o_rsp.fire      = (i_req.op == BOP_STEP) && cd_zero && r_used[addr] && !r_main[addr];
        o_rsp.pending   = cnt_rd;
        o_rsp.alloc_ok  = found_ok;
        o_rsp.alloc_idx = 3'(found_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_main <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_reload[i] <= PERIOD_BITS'(RESET_PERIOD);
                r_cd[i]     <= '0;
                r_cnt[i]    <= '0;
            end
        end else begin
            case (i_req.op)
                BOP_STEP: begin
                    if (!cd_zero) begin
                        r_cd[addr] <= cd_rd - 1'b1;
                    end else begin
                        r_cd[addr] <= r_reload[addr];
                        if (cnt_rd != COUNT_MAX) begin
                            r_cnt[addr] <= cnt_rd + 8'd1;
                        end
                    end
                end
                BOP_ALLOC: begin
                    if (found_ok) begin
                        r_used[addr]   <= 1'b1;
                        r_main[addr]   <= i_req.in_main;
                        r_reload[addr] <= i_req.period;
                        r_cd[addr]     <= i_req.period;
                        r_cnt[addr]    <= '0;
                    end
                end
                BOP_LOAD: begin
                    r_reload[addr] <= i_req.period;
                    r_cd[addr]     <= i_req.period;
                    r_cnt[addr]    <= '0;
                end
                BOP_CLEAR: begin
                    r_cnt[addr] <= '0;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

[sv/periodic_task_timer_bank_core.sv]
// Periodic task timer bank: top level, command sequencer, tick and stopwatch counters.
// Tick: one channel per cycle through the shared countdown unit;
// result strobed once the last channel has stepped, as busy drops for the next request.
// Other commands: executed in ST_EXEC, result strobed as it returns to idle; busy until then.
// Results are strobed for one cycle; the receiver cannot stall.
// Synchronous active-low reset clears all channels, tick time and stopwatch.
module periodic_task_timer_bank_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic [2:0]  i_channel,
    input  logic [15:0] i_period_ticks,
    input  logic        i_run_in_main,
    output logic        o_done,
    output logic [7:0]  o_fire_mask,
    output logic        o_alloc_ok,
    output logic [2:0]  o_alloc_index,
    output logic [7:0]  o_pending_count,
    output logic [31:0] o_time_value
);
    import ptt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_TICK = 3'b010,
        ST_EXEC = 3'b100
    } t_state;

    t_state                 r_state;
    logic [CH_IDX_W-1:0]    r_idx;
    logic [2:0]             r_cmd;
    logic [2:0]             r_chan;
    logic [PERIOD_BITS-1:0] r_period;
    logic                   r_main;
    logic [MASK_W-1:0]      r_mask;
    logic [31:0]            r_tick_time;
    logic [31:0]            r_sw_start;

    logic                   r_done;
    logic [7:0]             r_fire_mask;
    logic                   r_alloc_ok;
    logic [2:0]             r_alloc_index;
    logic [7:0]             r_pending;
    logic [31:0]            r_time_value;

    logic [MASK_W-1:0]      n_mask;
    logic                   chan_ok;
    logic                   last_idx;
    t_bank_req              req;
    t_bank_rsp              rsp;

    assign busy     = (r_state != ST_IDLE);
    assign chan_ok  = (32'(r_chan) < CHANNELS);
    assign last_idx = (r_idx == CH_IDX_W'(CHANNELS - 1));

    always_comb begin
        req.op      = BOP_NONE;
        req.idx     = CH_IDX_W'(r_chan);
        req.period  = r_period;
        req.in_main = r_main;
        if (r_state == ST_TICK) begin
            req.op  = BOP_STEP;
            req.idx = r_idx;
        end else if (r_state == ST_EXEC) begin
            case (r_cmd)
                CMD_ALLOC:    req.op = BOP_ALLOC;
                CMD_SET_PER:  req.op = chan_ok ? BOP_LOAD : BOP_NONE;
                CMD_TEST_CLR: req.op = chan_ok ? BOP_CLEAR : BOP_NONE;
                default:      req.op = BOP_NONE;
            endcase
        end
    end

    ptt_chan_bank u_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    // channels at index 8 and up never show in the mask
    always_comb begin
        n_mask = r_mask;
        for (int j = 0; j < MASK_W; j++) begin
            if (rsp.fire && (32'(r_idx) == j)) begin
                n_mask[j] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_mask      <= '0;
            r_tick_time <= '0;
            r_sw_start  <= '0;
            r_done      <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_cmd    <= i_cmd;
                        r_chan   <= i_channel;
                        r_period <= PERIOD_BITS'(i_period_ticks);
                        r_main   <= i_run_in_main;
                        r_idx    <= '0;
                        r_mask   <= '0;
                        r_state  <= (i_cmd == CMD_TICK) ? ST_TICK : ST_EXEC;
                    end
                end
                ST_TICK: begin
                    r_mask <= n_mask;
                    r_idx  <= r_idx + 1'b1;
                    if (last_idx) begin
                        r_tick_time   <= r_tick_time + 32'd1;
                        r_done        <= 1'b1;
                        r_fire_mask   <= n_mask;
                        r_alloc_ok    <= 1'b0;
                        r_alloc_index <= '0;
                        r_pending     <= '0;
                        r_time_value  <= '0;
                        r_state       <= ST_IDLE;
                    end
                end
                ST_EXEC: begin
                    r_done        <= 1'b1;
                    r_fire_mask   <= '0;
                    r_alloc_ok    <= 1'b0;
                    r_alloc_index <= '0;
                    r_pending     <= '0;
                    r_time_value  <= '0;
                    case (r_cmd)
                        CMD_ALLOC: begin
                            r_alloc_ok    <= rsp.alloc_ok;
                            r_alloc_index <= rsp.alloc_ok ? rsp.alloc_idx : 3'd0;
                        end
                        CMD_TEST_CLR: r_pending    <= chan_ok ? rsp.pending : 8'd0;
                        CMD_RD_TIME:  r_time_value <= r_tick_time;
                        CMD_SW_START: r_sw_start   <= r_tick_time;
                        CMD_ELAPSED:  r_time_value <= r_tick_time - r_sw_start;
                        default: begin
                        end
                    endcase
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_done          = r_done;
    assign o_fire_mask     = r_fire_mask;
    assign o_alloc_ok      = r_alloc_ok;
    assign o_alloc_index   = r_alloc_index;
    assign o_pending_count = r_pending;
    assign o_time_value    = r_time_value;

endmodule
